// ===== hdl/mnbh_pkg.sv =====
// mnbh_pkg: types and constants shared by the name bucket hash block
// holds the mix constants, the datapath op codes and the control/status structs
// no dependencies

package mnbh_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
   localparam int          MIX_SHIFT   = 24;
   localparam int          FIN_SHIFT_A = 13;
   localparam int          FIN_SHIFT_B = 15;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_MIX1,
      OP_MIX2,
      OP_MIX3,
      OP_FIN0,
      OP_FIN1,
      OP_FIN2,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic take_word;
      logic name_end;
      logic mod_busy;
      logic rsp_free;
   } status_type;

endpackage

// ===== hdl/mnbh_if.sv =====
// mnbh_req_if, mnbh_rsp_if, mnbh_csr_if: valid/ready channels of the hash block
// request carries name bytes, response the bucket and hash, csr the seed
// no dependencies

interface mnbh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] name_byte;
   logic       byte_valid;
   logic       last;
   logic [9:0] max_length;

   modport source (output valid, name_byte, byte_valid, last, max_length, input ready);
   modport sink   (input valid, name_byte, byte_valid, last, max_length, output ready);
endinterface

interface mnbh_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  bucket;
   logic [31:0] full_hash;

   modport source (output valid, bucket, full_hash, input ready);
   modport sink   (input valid, bucket, full_hash, output ready);
endinterface

interface mnbh_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] seed;

   modport source (output valid, seed, input ready);
   modport sink   (input valid, seed, output ready);
endinterface

// ===== hdl/mnbh_mod.sv =====
// mnbh_mod: remainder of a 32-bit hash by the constant table size
// reciprocal multiply, back multiply and subtract, then one correction step, each a registered step
// depends on nothing beyond its parameter

module mnbh_mod #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [31:0]                      value,
   output logic [$clog2(TABLE_SIZE):0]      rem,
   output logic                             busy
);

   localparam int RW = $clog2(TABLE_SIZE) + 1;
   localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / TABLE_SIZE);
   localparam logic [31:0] DIVISOR = 32'(TABLE_SIZE);

   localparam logic [1:0] STEP_QUO = 2'd0;
   localparam logic [1:0] STEP_SUB = 2'd1;
   localparam logic [1:0] STEP_FIX = 2'd2;

   logic [31:0] val_ff, val_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [63:0] recip_prod;
   logic [31:0] back_prod;

   // quotient estimate is the true quotient or one below it
   assign recip_prod = 64'(val_ff) * 64'(RECIP);
   assign back_prod  = quo_ff * DIVISOR;

   always_comb begin
      val_in  = val_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         val_in  = value;
         step_in = STEP_QUO;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         unique case (step_ff)
            STEP_QUO: begin
               quo_in  = recip_prod[63:32];
               step_in = STEP_SUB;
            end
            STEP_SUB: begin
               rem_in  = val_ff - back_prod;
               step_in = STEP_FIX;
            end
            default: begin
               if (rem_ff >= DIVISOR) begin
                  rem_in = rem_ff - DIVISOR;
               end
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      val_ff  <= val_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign rem  = rem_ff[RW-1:0];
   assign busy = busy_ff;

endmodule

// ===== hdl/mnbh_dp.sv =====
// mnbh_dp: hash datapath with name state, one shared constant multiplier and result register
// executes one op per cycle from the controller, reports status back
// depends on mnbh_pkg and mnbh_mod

module mnbh_dp #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mnbh_pkg::cmd_type    cmd,
   output mnbh_pkg::status_type status,
   input  logic [7:0]           req_name_byte,
   input  logic                 req_byte_valid,
   input  logic                 req_last,
   input  logic [9:0]           req_max_length,
   input  logic                 csr_valid,
   input  logic [7:0]           csr_seed,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [9:0]           rsp_bucket,
   output logic [31:0]          rsp_full_hash
);

   localparam int RW = $clog2(TABLE_SIZE) + 1;

   logic [7:0]  seed_ff;
   logic [31:0] hash_ff, hash_in;
   logic [23:0] word_ff, word_in;
   logic [1:0]  phase_ff, phase_in;
   logic [9:0]  taken_ff, taken_in;
   logic [9:0]  limit_ff, limit_in;
   logic        in_name_ff, in_name_in;
   logic [31:0] k_ff, k_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [9:0]  bucket_ff;
   logic [31:0] full_ff, full_in;

   logic        first;
   logic [31:0] hash_e;
   logic [23:0] word_e;
   logic [1:0]  phase_e;
   logic [9:0]  taken_e;
   logic [9:0]  limit_e;
   logic        take;
   logic [31:0] mul_a, mul_p;
   logic [31:0] fin_v;
   logic        mod_start;
   logic        mod_busy;
   logic [RW-1:0]  mod_rem;
   logic [RW+9:0]  rem_wide;

   assign first   = !in_name_ff;
   assign hash_e  = first ? {22'd0, req_max_length} ^ {24'd0, seed_ff} : hash_ff;
   assign word_e  = first ? '0 : word_ff;
   assign phase_e = first ? '0 : phase_ff;
   assign taken_e = first ? '0 : taken_ff;
   assign limit_e = first ? req_max_length : limit_ff;
   assign take    = req_byte_valid && (taken_e < limit_e);

   assign fin_v = k_ff ^ (k_ff >> mnbh_pkg::FIN_SHIFT_B);

   always_comb begin
      unique case (cmd.op)
         mnbh_pkg::OP_MIX1: mul_a = k_ff;
         mnbh_pkg::OP_MIX2: mul_a = k_ff ^ (k_ff >> mnbh_pkg::MIX_SHIFT);
         mnbh_pkg::OP_FIN0: mul_a = hash_ff ^ {8'd0, word_ff};
         mnbh_pkg::OP_FIN1: mul_a = k_ff ^ (k_ff >> mnbh_pkg::FIN_SHIFT_A);
         default:           mul_a = hash_ff;
      endcase
   end

   assign mul_p = mul_a * mnbh_pkg::MIX_MUL;

   always_comb begin
      hash_in      = hash_ff;
      word_in      = word_ff;
      phase_in     = phase_ff;
      taken_in     = taken_ff;
      limit_in     = limit_ff;
      in_name_in   = in_name_ff;
      k_in         = k_ff;
      full_in      = full_ff;
      mod_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (cmd.op)
         mnbh_pkg::OP_ACCEPT: begin
            in_name_in = 1'b1;
            limit_in   = limit_e;
            hash_in    = hash_e;
            word_in    = word_e;
            phase_in   = phase_e;
            taken_in   = taken_e;
            if (take) begin
               taken_in = taken_e + 10'd1;
               if (phase_e == 2'd3) begin
                  k_in     = {req_name_byte, word_e};
                  word_in  = '0;
                  phase_in = '0;
               end else begin
                  unique case (phase_e)
                     2'd0:    word_in = {word_e[23:8], req_name_byte};
                     2'd1:    word_in = {word_e[23:16], req_name_byte, word_e[7:0]};
                     default: word_in = {req_name_byte, word_e[15:0]};
                  endcase
                  phase_in = phase_e + 2'd1;
               end
            end
         end
         mnbh_pkg::OP_MIX1: k_in = mul_p;
         mnbh_pkg::OP_MIX2: k_in = mul_p;
         mnbh_pkg::OP_MIX3: hash_in = mul_p ^ k_ff;
         mnbh_pkg::OP_FIN0: k_in = (phase_ff != 2'd0) ? mul_p : hash_ff;
         mnbh_pkg::OP_FIN1: k_in = mul_p;
         mnbh_pkg::OP_FIN2: begin
            mod_start = 1'b1;
         end
         mnbh_pkg::OP_EMIT: begin
            full_in      = fin_v;
            rsp_valid_in = 1'b1;
            in_name_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   mnbh_mod #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .value (fin_v),
      .rem   (mod_rem),
      .busy  (mod_busy)
   );

   assign rem_wide = {10'd0, mod_rem};

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         in_name_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            seed_ff <= csr_seed;
         end
         in_name_ff   <= in_name_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hash_ff  <= hash_in;
      word_ff  <= word_in;
      phase_ff <= phase_in;
      taken_ff <= taken_in;
      limit_ff <= limit_in;
      k_ff     <= k_in;
      full_ff  <= full_in;
      if (cmd.op == mnbh_pkg::OP_EMIT) begin
         bucket_ff <= rem_wide[9:0];
      end
   end

   assign status.take_word = take && (phase_e == 2'd3);
   assign status.name_end  = req_last || (first && !req_byte_valid);
   assign status.mod_busy  = mod_busy;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bucket    = bucket_ff;
   assign rsp_full_hash = full_ff;

endmodule

// ===== hdl/mnbh_ctrl.sv =====
// mnbh_ctrl: sequencer for the hash block
// takes a request transfer, steps word mix and finalize ops, waits for the remainder and a free response slot
// depends on mnbh_pkg

module mnbh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mnbh_pkg::status_type status,
   output mnbh_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MIX1 = 3'd1;
   localparam logic [2:0] S_MIX2 = 3'd2;
   localparam logic [2:0] S_MIX3 = 3'd3;
   localparam logic [2:0] S_FIN0 = 3'd4;
   localparam logic [2:0] S_FIN1 = 3'd5;
   localparam logic [2:0] S_FIN2 = 3'd6;
   localparam logic [2:0] S_MOD  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       end_pend_ff, end_pend_in;

   always_comb begin
      state_in    = state_ff;
      end_pend_in = end_pend_ff;
      cmd.op      = mnbh_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op      = mnbh_pkg::OP_ACCEPT;
               end_pend_in = status.name_end;
               if (status.take_word) begin
                  state_in = S_MIX1;
               end else if (status.name_end) begin
                  state_in = S_FIN0;
               end
            end
         end
         S_MIX1: begin
            cmd.op   = mnbh_pkg::OP_MIX1;
            state_in = S_MIX2;
         end
         S_MIX2: begin
            cmd.op   = mnbh_pkg::OP_MIX2;
            state_in = S_MIX3;
         end
         S_MIX3: begin
            cmd.op   = mnbh_pkg::OP_MIX3;
            state_in = end_pend_ff ? S_FIN0 : S_IDLE;
         end
         S_FIN0: begin
            cmd.op   = mnbh_pkg::OP_FIN0;
            state_in = S_FIN1;
         end
         S_FIN1: begin
            cmd.op   = mnbh_pkg::OP_FIN1;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            cmd.op   = mnbh_pkg::OP_FIN2;
            state_in = S_MOD;
         end
         default: begin
            if (!status.mod_busy && status.rsp_free) begin
               cmd.op   = mnbh_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         end_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         end_pend_ff <= end_pend_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// ===== hdl/murmur2_name_bucket_hash.sv =====
// murmur2_name_bucket_hash: streaming name hash with bucket index, controller plus datapath
// a byte that completes a word takes three passes through one multiplier (ops MIX1, MIX2, MIX3)
// the transfer that ends a name goes through the finalize ops FIN0 and FIN1 on the shared multiplier,
// FIN2 to start the remainder unit, its quotient, subtract and correction steps, then the result load
// a new transfer is taken only in the idle state, not while a word is mixed or a result is finished,
// nor while a result waits behind an unaccepted one; synchronous active-high reset clears the seed

module murmur2_name_bucket_hash #(
   parameter int TABLE_SIZE = 1024
) (
   input logic             clock,
   input logic             reset,
   mnbh_req_if.sink        req_ch,
   mnbh_rsp_if.source      rsp_ch,
   mnbh_csr_if.sink        csr_ch
);

   mnbh_pkg::cmd_type    cmd;
   mnbh_pkg::status_type status;
   logic                 req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   mnbh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mnbh_dp #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_name_byte  (req_ch.name_byte),
      .req_byte_valid (req_ch.byte_valid),
      .req_last       (req_ch.last),
      .req_max_length (req_ch.max_length),
      .csr_valid      (csr_ch.valid),
      .csr_seed       (csr_ch.seed),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_bucket     (rsp_ch.bucket),
      .rsp_full_hash  (rsp_ch.full_hash)
   );

endmodule

// ===== sim/tb_murmur2_name_bucket_hash.sv =====
`timescale 1ns / 1ps
// tb_murmur2_name_bucket_hash: self-checking testbench for the streaming name bucket hash
// streams names byte by byte and checks each bucket and hash against its own predictor
// depends on mnbh_pkg, the mnbh_if channel interfaces and murmur2_name_bucket_hash

module tb_murmur2_name_bucket_hash;

   localparam int TABLE_SIZE  = 1024;
   localparam int SETTLE      = 20;
   localparam int ITEM_TARGET = 1150;

   typedef struct packed {
      logic [7:0] name_byte;
      logic       byte_valid;
      logic       last;
      logic [9:0] max_length;
   } name_item_type;

   typedef struct packed {
      logic [9:0]  bucket;
      logic [31:0] full_hash;
   } bucket_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mnbh_req_if req_if();
   mnbh_rsp_if rsp_if();
   mnbh_csr_if csr_if();

   murmur2_name_bucket_hash #(.TABLE_SIZE(TABLE_SIZE)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [7:0]  seed_r      = '0;
   logic [31:0] hash_acc    = '0;
   logic [23:0] word_buf    = '0;
   logic [1:0]  byte_phase  = '0;
   logic [9:0]  bytes_taken = '0;
   logic [9:0]  limit_hold  = '0;
   logic        in_name     = 1'b0;

   bucket_result_type pending_buckets[$];
   int  errors = 0;
   int  items_sent = 0;
   int  names_sent = 0;
   int  results_seen = 0;
   bit  no_idle = 1'b0;
   int  rsp_hold_cycles = 0;

   function automatic name_item_type make_item(input logic [7:0] b, input logic bv,
                                               input logic l, input logic [9:0] m);
      name_item_type it;
      it.name_byte  = b;
      it.byte_valid = bv;
      it.last       = l;
      it.max_length = m;
      return it;
   endfunction

   function automatic bit hash_name_byte(input name_item_type it,
                                         output bucket_result_type res);
      logic        first;
      logic [31:0] k;
      logic [31:0] h;
      res = '0;
      first = !in_name;
      if (first) begin
         limit_hold  = it.max_length;
         hash_acc    = {24'd0, seed_r} ^ {22'd0, it.max_length};
         word_buf    = '0;
         byte_phase  = '0;
         bytes_taken = '0;
         in_name     = 1'b1;
      end
      if (it.byte_valid && bytes_taken < limit_hold) begin
         if (byte_phase == 2'd3) begin
            k = {it.name_byte, word_buf};
            k = k * mnbh_pkg::MIX_MUL;
            k = k ^ (k >> mnbh_pkg::MIX_SHIFT);
            k = k * mnbh_pkg::MIX_MUL;
            hash_acc = (hash_acc * mnbh_pkg::MIX_MUL) ^ k;
            word_buf = '0;
            byte_phase = '0;
         end else begin
            word_buf = word_buf | ({16'd0, it.name_byte} << (8 * byte_phase));
            byte_phase = byte_phase + 2'd1;
         end
         bytes_taken = bytes_taken + 10'd1;
      end
      if (!(it.last || (first && !it.byte_valid)))
         return 1'b0;
      h = hash_acc;
      if (byte_phase != 2'd0) begin
         h = h ^ {8'd0, word_buf};
         h = h * mnbh_pkg::MIX_MUL;
      end
      h = h ^ (h >> mnbh_pkg::FIN_SHIFT_A);
      h = h * mnbh_pkg::MIX_MUL;
      h = h ^ (h >> mnbh_pkg::FIN_SHIFT_B);
      res.full_hash = h;
      res.bucket    = 10'(h % TABLE_SIZE);
      hash_acc    = '0;
      word_buf    = '0;
      byte_phase  = '0;
      bytes_taken = '0;
      limit_hold  = '0;
      in_name     = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      errors++;
   endtask

   task automatic send_item(input name_item_type it);
      bucket_result_type res;
      if (!no_idle && $urandom_range(0, 99) < 11) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.name_byte  <= it.name_byte;
      req_if.byte_valid <= it.byte_valid;
      req_if.last       <= it.last;
      req_if.max_length <= it.max_length;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      items_sent++;
      if (hash_name_byte(it, res))
         pending_buckets.push_back(res);
   endtask

   task automatic send_name(input int len, input logic [9:0] lim, input int bubble_pct,
                            input bit end_on_bubble);
      names_sent++;
      if (len == 0) begin
         send_item(make_item(8'($urandom), 1'b0, 1'($urandom), lim));
         return;
      end
      for (int pos = 0; pos < len; pos++) begin
         if (pos > 0 && $urandom_range(0, 99) < bubble_pct)
            send_item(make_item(8'($urandom), 1'b0, 1'b0, 10'($urandom)));
         send_item(make_item(8'($urandom), 1'b1, pos == len - 1 && !end_on_bubble,
                             pos == 0 ? lim : 10'($urandom)));
      end
      if (end_on_bubble)
         send_item(make_item(8'($urandom), 1'b0, 1'b1, 10'($urandom)));
   endtask

   task automatic send_random_name();
      int len;
      int pick;
      logic [9:0] lim;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         len = 0;
      else if (pick < 85)
         len = $urandom_range(1, 12);
      else
         len = $urandom_range(13, 40);
      pick = $urandom_range(0, 99);
      if (pick < 55)
         lim = 10'($urandom_range(len, 512));
      else if (pick < 75)
         lim = 10'($urandom_range(0, len));
      else if (pick < 83)
         lim = '0;
      else
         lim = 10'($urandom_range(513, 1023));
      send_name(len, lim, ($urandom_range(0, 99) < 20) ? 15 : 0,
                $urandom_range(0, 99) < 12);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_buckets.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_seed(input logic [7:0] value);
      csr_if.valid <= 1'b1;
      csr_if.seed  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      seed_r = value;
   endtask

   task automatic test_directed();
      name_item_type items[$];
      items = '{
         make_item(8'h00, 1'b0, 1'b0, 10'd0),
         make_item(8'hff, 1'b0, 1'b1, 10'd1023),
         make_item(8'h00, 1'b1, 1'b1, 10'd1),
         make_item(8'hff, 1'b1, 1'b1, 10'd512),
         make_item(8'hff, 1'b1, 1'b0, 10'd1023),
         make_item(8'hff, 1'b1, 1'b0, 10'd0),
         make_item(8'hff, 1'b1, 1'b0, 10'd0),
         make_item(8'hff, 1'b1, 1'b1, 10'd0),
         make_item(8'h61, 1'b1, 1'b0, 10'd3),
         make_item(8'h62, 1'b1, 1'b0, 10'd1023),
         make_item(8'h63, 1'b1, 1'b1, 10'd1023),
         make_item(8'h11, 1'b1, 1'b0, 10'd2),
         make_item(8'h22, 1'b1, 1'b0, 10'd512),
         make_item(8'h33, 1'b1, 1'b0, 10'd512),
         make_item(8'h44, 1'b1, 1'b0, 10'd512),
         make_item(8'h55, 1'b1, 1'b1, 10'd512),
         make_item(8'h80, 1'b1, 1'b0, 10'd0),
         make_item(8'h7f, 1'b1, 1'b1, 10'd1023),
         make_item(8'ha5, 1'b1, 1'b0, 10'd700),
         make_item(8'h00, 1'b0, 1'b0, 10'd0),
         make_item(8'h5a, 1'b1, 1'b0, 10'd1023),
         make_item(8'hff, 1'b0, 1'b1, 10'd0)
      };
      foreach (items[i])
         send_item(items[i]);
      names_sent += 9;
   endtask

   task automatic test_long_name();
      send_name(160, 10'd150, 10, 1'b0);
      send_name(40, 10'd1023, 0, 1'b0);
   endtask

   task automatic test_backpressure();
      rsp_hold_cycles = 300;
      repeat (40) send_name(1, 10'($urandom), 0, 1'b0);
   endtask

   task automatic test_pause();
      repeat (8) send_random_name();
      wait_idle();
      repeat (8) send_random_name();
   endtask

   task automatic test_seed_settings();
      logic [7:0] seeds[$];
      seeds = '{8'hff, 8'h5a, 8'($urandom), 8'h80};
      foreach (seeds[i]) begin
         wait_idle();
         write_seed(seeds[i]);
         repeat (10) send_random_name();
      end
   endtask

   task automatic test_no_idle();
      no_idle = 1'b1;
      repeat (20) send_random_name();
      no_idle = 1'b0;
   endtask

   task automatic test_random_bulk();
      while (items_sent < ITEM_TARGET) send_random_name();
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 11);
         end
      end
   end

   always @(posedge clock) begin : check_results
      bucket_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         results_seen++;
         if (pending_buckets.size() == 0) begin
            report_mismatch("unexpected result hash", rsp_if.full_hash, 32'd0);
         end else begin
            want = pending_buckets.pop_front();
            if (rsp_if.bucket !== want.bucket)
               report_mismatch("bucket", {22'd0, rsp_if.bucket}, {22'd0, want.bucket});
            if (rsp_if.full_hash !== want.full_hash)
               report_mismatch("full_hash", rsp_if.full_hash, want.full_hash);
         end
      end
   end

   initial begin
      req_if.valid      <= 1'b0;
      req_if.name_byte  <= '0;
      req_if.byte_valid <= 1'b0;
      req_if.last       <= 1'b0;
      req_if.max_length <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.seed       <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_seed(8'h00);
      test_directed();
      test_long_name();
      test_backpressure();
      test_pause();
      test_seed_settings();
      test_no_idle();
      test_random_bulk();
      wait_idle();
      $display("covered %0d byte transfers in %0d names, %0d results checked",
               items_sent, names_sent, results_seen);
      $display("seeds 00, ff, 5a, 80 and one random; long names, limits, bubbles, stalls");
      if (errors == 0)
         $display("** murmur2_name_bucket_hash: PASSED **");
      else
         $display("** murmur2_name_bucket_hash: FAILED **");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout waiting on the hash block");
      $display("** murmur2_name_bucket_hash: FAILED **");
      $finish;
   end

endmodule
